@@ rtl/tcgr_pkg.sv @@
// Shared types, codes and color helper for the text cell glyph renderer.
`default_nettype none

package tcgr_pkg;

   localparam int FONT_WORDS      = 256;
   localparam int FONT_LINES      = FONT_WORDS / 2;
   localparam int PALETTE_ENTRIES = 16;

   localparam int FONT_AW = $clog2(FONT_LINES);
   localparam int PAL_AW  = $clog2(PALETTE_ENTRIES);

   localparam logic [2:0] ACT_TICK   = 3'd0;
   localparam logic [2:0] ACT_CELL   = 3'd1;
   localparam logic [2:0] ACT_FONT   = 3'd2;
   localparam logic [2:0] ACT_PAL    = 3'd3;
   localparam logic [2:0] ACT_BORDER = 3'd4;

   localparam logic [1:0] REG_REFRESH_PERIOD = 2'd0;
   localparam logic [1:0] REG_BLINK_HALF     = 2'd1;
   localparam logic [1:0] REG_DISPLAY_ENABLE = 2'd2;
   localparam logic [1:0] REG_BORDER_INDEX   = 2'd3;

   localparam logic [15:0] RESET_REFRESH_PERIOD = 16'd1666;
   localparam logic [15:0] RESET_BLINK_HALF     = 16'd30;

   localparam logic [2:0] LAST_ROW = 3'd7;

   typedef struct packed {
      logic [2:0]  action;
      logic [15:0] cell_word;
      logic [7:0]  table_index;
      logic [15:0] table_data;
   } req_type;

   typedef struct packed {
      logic [2:0]  row;
      logic [23:0] pixel_a_rgb;
      logic [23:0] pixel_b_rgb;
      logic [23:0] pixel_c_rgb;
      logic [23:0] pixel_d_rgb;
      logic        last;
      logic        refresh_due;
      logic [23:0] border_rgb;
   } rsp_type;

   // widen each nibble n to the byte n * 0x11
   function automatic logic [23:0] expand_color(input logic [11:0] c);
      return {c[11:8], c[11:8], c[7:4], c[7:4], c[3:0], c[3:0]};
   endfunction

endpackage

`default_nettype wire

@@ rtl/text_cell_glyph_renderer.sv @@
// Top level of the text cell glyph renderer: stores, counters, row sequencer.
//
// Input channel req_*: one word per action (tick, render cell, font write,
// palette write, border query). Result channel rsp_*: one word per result.
// Configuration registers sit on an APB-style port at byte addresses 0, 4,
// 8 and 12; pready is always high and writes land in the access cycle.
// A tick or border query yields one result; a cell yields eight row results,
// rows 0 to 7, last set on row 7; font and palette writes yield nothing.
// Each result is registered in the sequencer stage and then in the output
// register. Results leave one per cycle while rsp is not stalled, so ticks
// and queries flow one per cycle; a cell occupies the row sequencer until
// its last row goes out, and writes leave the sequencer without a result.
// Font (128 x 32) and palette (16 x 12, two read ports) memories have a
// registered read issued as the item is taken.
// Reset clears the counters, the sequencer and the output valid flag and loads
// the register defaults; both memories are undefined until written.
// A stalled rsp holds its word; a tick, query or cell in the sequencer then holds and raises req_stall.
`default_nettype none

module text_cell_glyph_renderer import tcgr_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire req_type     req_data,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output rsp_type          rsp_data,
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [3:0]  paddr,
   input  wire logic [31:0] pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);

   logic [15:0] refresh_period_ff;
   logic [15:0] blink_half_ff;
   logic        display_enable_ff;
   logic [3:0]  border_index_ff;

   logic [16:0] refresh_count_ff, refresh_count_in;
   logic [16:0] blink_count_ff, blink_count_in;

   logic [31:0] font_mem [FONT_LINES];
   logic [11:0] pal_mem [PALETTE_ENTRIES];
   logic [31:0] font_rd_ff;
   logic [11:0] pal_a_rd_ff;
   logic [11:0] pal_b_rd_ff;

   logic        s1_valid_ff;
   logic [2:0]  s1_action_ff;
   logic        s1_blank_fg_ff;
   logic        s1_due_ff;
   logic [2:0]  s1_row_ff;

   logic        rsp_valid_ff;
   rsp_type     rsp_ff, rsp_in;

   logic        accept;
   logic        cfg_write;
   logic        out_free;
   logic        s1_is_cell, s1_is_single, s1_emits, s1_finish;
   logic        due_in;
   logic [16:0] refresh_inc, blink_inc;
   logic [11:0] fg_raw;
   logic [23:0] fg_rgb, bg_rgb;
   logic [15:0] glyph_w0, glyph_w1;
   logic [PAL_AW-1:0] pal_b_addr;

   assign pready    = 1'b1;
   assign cfg_write = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         refresh_period_ff <= RESET_REFRESH_PERIOD;
         blink_half_ff     <= RESET_BLINK_HALF;
         display_enable_ff <= 1'b1;
         border_index_ff   <= '0;
      end else if (cfg_write) begin
         unique case (paddr[3:2])
            REG_REFRESH_PERIOD: refresh_period_ff <= pwdata[15:0];
            REG_BLINK_HALF:     blink_half_ff     <= pwdata[15:0];
            REG_DISPLAY_ENABLE: display_enable_ff <= pwdata[0];
            REG_BORDER_INDEX:   border_index_ff   <= pwdata[3:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[3:2])
         REG_REFRESH_PERIOD: prdata = {16'd0, refresh_period_ff};
         REG_BLINK_HALF:     prdata = {16'd0, blink_half_ff};
         REG_DISPLAY_ENABLE: prdata = {31'd0, display_enable_ff};
         REG_BORDER_INDEX:   prdata = {28'd0, border_index_ff};
         default:            prdata = '0;
      endcase
   end

   assign out_free     = !rsp_valid_ff || !rsp_stall;
   assign s1_is_cell   = s1_action_ff == ACT_CELL;
   assign s1_is_single = s1_action_ff == ACT_TICK || s1_action_ff == ACT_BORDER;
   assign s1_emits     = s1_valid_ff && (s1_is_cell || s1_is_single) && out_free;
   assign s1_finish    = s1_valid_ff &&
                         (!(s1_is_cell || s1_is_single) ||
                          (out_free && (s1_is_single || s1_row_ff == LAST_ROW)));
   assign req_stall    = s1_valid_ff && !s1_finish;
   assign accept       = req_valid && !req_stall;

   assign refresh_inc = refresh_count_ff + 17'd1;
   assign blink_inc   = blink_count_ff + 17'd1;
   assign due_in      = refresh_inc > {1'b0, refresh_period_ff};

   always_comb begin
      refresh_count_in = refresh_count_ff;
      blink_count_in   = blink_count_ff;
      if (accept && req_data.action == ACT_TICK) begin
         refresh_count_in = due_in ? '0 : refresh_inc;
         blink_count_in   = (blink_inc > {blink_half_ff, 1'b0}) ? '0 : blink_inc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         refresh_count_ff <= '0;
         blink_count_ff   <= '0;
      end else begin
         refresh_count_ff <= refresh_count_in;
         blink_count_ff   <= blink_count_in;
      end
   end

   // font memory: line = character, low half = even word, high half = odd word
   always_ff @(posedge clock) begin
      if (accept && req_data.action == ACT_FONT) begin
         if (req_data.table_index[0]) begin
            font_mem[req_data.table_index[7:1]][31:16] <= req_data.table_data;
         end else begin
            font_mem[req_data.table_index[7:1]][15:0] <= req_data.table_data;
         end
      end
      if (accept) begin
         font_rd_ff <= font_mem[req_data.cell_word[FONT_AW-1:0]];
      end
   end

   assign pal_b_addr = (req_data.action == ACT_BORDER) ? border_index_ff
                                                        : req_data.cell_word[11:8];

   always_ff @(posedge clock) begin
      if (accept && req_data.action == ACT_PAL && req_data.table_index[7:PAL_AW] == '0) begin
         pal_mem[req_data.table_index[PAL_AW-1:0]] <= req_data.table_data[11:0];
      end
      if (accept) begin
         pal_a_rd_ff <= pal_mem[req_data.cell_word[15:12]];
         pal_b_rd_ff <= pal_mem[pal_b_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s1_row_ff   <= '0;
      end else begin
         if (accept) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_finish) begin
            s1_valid_ff <= 1'b0;
         end
         if (s1_finish) begin
            s1_row_ff <= '0;
         end else if (s1_emits) begin
            s1_row_ff <= s1_row_ff + 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_action_ff   <= req_data.action;
         s1_blank_fg_ff <= req_data.cell_word[7] && (blink_count_ff > {1'b0, blink_half_ff});
         s1_due_ff      <= due_in;
      end
   end

   assign fg_raw   = s1_blank_fg_ff ? pal_b_rd_ff : pal_a_rd_ff;
   assign fg_rgb   = expand_color(fg_raw);
   assign bg_rgb   = expand_color(pal_b_rd_ff);
   assign glyph_w0 = font_rd_ff[15:0];
   assign glyph_w1 = font_rd_ff[31:16];

   always_comb begin
      rsp_in = '0;
      if (s1_is_cell) begin
         rsp_in.row  = s1_row_ff;
         rsp_in.last = s1_row_ff == LAST_ROW;
         if (display_enable_ff) begin
            rsp_in.pixel_a_rgb = glyph_w0[{1'b1, s1_row_ff}] ? fg_rgb : bg_rgb;
            rsp_in.pixel_b_rgb = glyph_w0[{1'b0, s1_row_ff}] ? fg_rgb : bg_rgb;
            rsp_in.pixel_c_rgb = glyph_w1[{1'b1, s1_row_ff}] ? fg_rgb : bg_rgb;
            rsp_in.pixel_d_rgb = glyph_w1[{1'b0, s1_row_ff}] ? fg_rgb : bg_rgb;
         end
      end else if (s1_action_ff == ACT_TICK) begin
         rsp_in.last        = 1'b1;
         rsp_in.refresh_due = s1_due_ff;
      end else begin
         rsp_in.last       = 1'b1;
         rsp_in.border_rgb = bg_rgb;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_emits) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_emits) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assert property (@(posedge clock) disable iff (reset)
      !s1_valid_ff |-> !req_stall)
      else $error("input stalled with an empty sequencer");

   assert property (@(posedge clock) disable iff (reset)
      s1_row_ff != '0 |-> s1_valid_ff && s1_is_cell)
      else $error("row counter running outside a cell");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_data.last |=> rsp_valid)
      else $error("cell row stream broken");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.last |-> rsp_data.row != LAST_ROW)
      else $error("row seven without last");

endmodule

`default_nettype wire
